// File: design/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PRQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("prq check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define PRQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("prq check failed");

`endif

// File: design/prq_pkg.sv
// types and codes of the priority ready queue
`timescale 1ns / 1ps
package prq_pkg;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_ROTATE = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SUSPENDED = 2'd1;
    localparam logic [1:0] ST_QUEUED = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] thread_id;
        logic [7:0] priority_req;
        logic [7:0] running_priority;
        logic       suspended;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic       need_resched;
        logic       any_ready;
        logic [7:0] highest_priority;
        logic [5:0] highest_thread;
        logic [6:0] ready_count;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LVL,
        S_RD_HEAD,
        S_UNLINK,
        S_APP_RDH,
        S_APP_RDP,
        S_APP_W1,
        S_APP_W2,
        S_ADD_EMPTY,
        S_FIND,
        S_OUT
    } t_state;

endpackage

// File: design/prq_ram.sv
// generic ram, one write port, one registered read port
`timescale 1ns / 1ps
module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/priority_ready_queue_top.sv
// priority ready queue: per-level thread rings in ram, occupancy bitmap in flops
// one item at a time: an ignored item skips to find, an add to an empty level writes
// head and links, a remove reads level and head then unlinks, an occupied add reads
// head and tail then writes links, a rotate unlinks and appends or advances the head
// synchronous active-low reset clears queued flags, bitmap, count and idle id
// rams need no clearing, links and heads are only read once written
`timescale 1ns / 1ps
module priority_ready_queue_top #(
    parameter int THREADS = 64,
    parameter int LEVELS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [5:0]        i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_stall,
    input  prq_pkg::t_in_item i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output prq_pkg::t_out_item o_out
);
    import prq_pkg::*;

    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);
    localparam int CW = $clog2(THREADS + 1);
    localparam int GROUPS = (LEVELS + 31) / 32;
    localparam int GSW = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    t_state r_state, n_state;
    logic [TW-1:0] r_tid, r_nx, r_pv, r_h;
    logic [LW-1:0] r_lv, r_hp;
    logic r_rot, r_any, r_resched, r_ovalid;
    logic [1:0] r_status;
    logic [THREADS-1:0] r_flag;
    logic [LEVELS-1:0] r_occ;
    logic [CW-1:0] r_cnt;
    logic [5:0] r_idle;
    t_out_item r_out;

    logic nxt_we, prv_we, head_we, lvl_we;
    logic [TW-1:0] nxt_wa, nxt_wd, nxt_ra, nxt_q, prv_wa, prv_wd, prv_ra, prv_q;
    logic [TW-1:0] head_wd, head_q, lvl_wa;
    logic [LW-1:0] head_wa, head_ra, lvl_wd, lvl_q;

    prq_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_nxt (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_raddr(nxt_ra), .o_rdata(nxt_q));
    prq_ram #(.WIDTH(TW), .DEPTH(THREADS)) u_prv (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_raddr(prv_ra), .o_rdata(prv_q));
    prq_ram #(.WIDTH(TW), .DEPTH(LEVELS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(head_ra), .o_rdata(head_q));
    prq_ram #(.WIDTH(LW), .DEPTH(THREADS)) u_lvl (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(lvl_wa), .i_wdata(lvl_wd),
        .i_raddr(nxt_ra), .o_rdata(lvl_q));

    logic accept, in_tvalid, in_flag, in_occ;
    logic [TW-1:0] in_tid;
    logic [LW-1:0] in_lv;
    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign in_tid = TW'(i_in.thread_id);
    assign in_tvalid = int'(i_in.thread_id) < THREADS;
    assign in_flag = in_tvalid && r_flag[in_tid];
    assign in_lv = (int'(i_in.priority_req) >= LEVELS) ? LW'(LEVELS - 1)
                                                        : LW'(i_in.priority_req);
    assign in_occ = r_occ[in_lv];

    // decode of an accepted item
    t_state dec_next;
    logic [1:0] dec_status;
    logic dec_add, dec_rem;
    always_comb begin
        dec_next = S_FIND;
        dec_status = ST_DONE;
        dec_add = 1'b0;
        dec_rem = 1'b0;
        if (!in_tvalid || i_in.mode == MODE_NONE) begin
            dec_status = ST_IGNORED;
        end else if (i_in.mode == MODE_ADD) begin
            if (i_in.suspended) begin
                dec_status = ST_SUSPENDED;
            end else if (in_flag) begin
                dec_status = ST_QUEUED;
            end else begin
                dec_add = 1'b1;
                dec_next = in_occ ? S_APP_RDH : S_ADD_EMPTY;
            end
        end else if (i_in.mode == MODE_REMOVE) begin
            if (i_in.thread_id == r_idle || !in_flag) begin
                dec_status = ST_IGNORED;
            end else begin
                dec_rem = 1'b1;
                dec_next = S_RD_LVL;
            end
        end else begin
            if (!in_flag) begin
                dec_status = ST_IGNORED;
            end else begin
                dec_next = S_RD_LVL;
            end
        end
    end

    // most urgent occupied level
    logic [GROUPS*32-1:0] occ_pad;
    logic [GSW-1:0] sel_g;
    logic [4:0] sel_b;
    logic [31:0] sel_word;
    logic [LW-1:0] find_hp;
    logic find_any;
    always_comb begin
        occ_pad = (GROUPS * 32)'(r_occ);
        sel_g = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (|occ_pad[g*32 +: 32]) sel_g = GSW'(g);
        end
        sel_word = occ_pad[int'(sel_g)*32 +: 32];
        sel_b = '0;
        for (int b = 31; b >= 0; b--) begin
            if (sel_word[b]) sel_b = 5'(b);
        end
        find_any = |r_occ;
        find_hp = find_any ? LW'(int'(sel_g) * 32 + int'(sel_b)) : '0;
    end

    logic unl_lone, head_is_t, out_go;
    assign unl_lone = (r_nx == r_tid);
    assign head_is_t = (head_q == r_tid);
    assign out_go = !r_ovalid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (accept) n_state = dec_next;
            S_RD_LVL:    n_state = S_RD_HEAD;
            S_RD_HEAD:   n_state = S_UNLINK;
            S_UNLINK:    n_state = (r_rot && !unl_lone && !head_is_t) ? S_APP_RDH : S_FIND;
            S_APP_RDH:   n_state = S_APP_RDP;
            S_APP_RDP:   n_state = S_APP_W1;
            S_APP_W1:    n_state = S_APP_W2;
            S_APP_W2:    n_state = S_FIND;
            S_ADD_EMPTY: n_state = S_FIND;
            S_FIND:      n_state = S_OUT;
            S_OUT:       if (out_go) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = '0;
        prv_we = 1'b0; prv_wa = '0; prv_wd = '0; prv_ra = '0;
        head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
        lvl_we = 1'b0; lvl_wa = '0; lvl_wd = '0;
        unique case (r_state)
            S_RD_LVL: begin
                nxt_ra = r_tid;
                prv_ra = r_tid;
            end
            S_RD_HEAD: head_ra = lvl_q;
            S_UNLINK: begin
                if (!unl_lone && (!r_rot || !head_is_t)) begin
                    prv_we = 1'b1; prv_wa = r_nx; prv_wd = r_pv;
                    nxt_we = 1'b1; nxt_wa = r_pv; nxt_wd = r_nx;
                end
                if (!unl_lone && head_is_t) begin
                    head_we = 1'b1; head_wa = r_lv; head_wd = r_nx;
                end
            end
            S_APP_RDH: head_ra = r_lv;
            S_APP_RDP: prv_ra = head_q;
            S_APP_W1: begin
                nxt_we = 1'b1; nxt_wa = prv_q; nxt_wd = r_tid;
                prv_we = 1'b1; prv_wa = r_tid; prv_wd = prv_q;
                lvl_we = 1'b1; lvl_wa = r_tid; lvl_wd = r_lv;
            end
            S_APP_W2: begin
                nxt_we = 1'b1; nxt_wa = r_tid; nxt_wd = r_h;
                prv_we = 1'b1; prv_wa = r_h; prv_wd = r_tid;
            end
            S_ADD_EMPTY: begin
                head_we = 1'b1; head_wa = r_lv; head_wd = r_tid;
                nxt_we = 1'b1; nxt_wa = r_tid; nxt_wd = r_tid;
                prv_we = 1'b1; prv_wa = r_tid; prv_wd = r_tid;
                lvl_we = 1'b1; lvl_wa = r_tid; lvl_wd = r_lv;
            end
            S_FIND: head_ra = find_hp;
            S_OUT: head_ra = r_hp;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flag <= '0;
            r_occ <= '0;
            r_cnt <= '0;
            r_idle <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_idle <= i_cfg_wdata;
            if (accept && dec_add) begin
                r_flag[in_tid] <= 1'b1;
                r_cnt <= r_cnt + CW'(1);
            end
            if (accept && dec_rem) begin
                r_flag[in_tid] <= 1'b0;
                if (r_cnt != '0) r_cnt <= r_cnt - CW'(1);
            end
            if (r_state == S_UNLINK && unl_lone && !r_rot) r_occ[r_lv] <= 1'b0;
            if (r_state == S_ADD_EMPTY) r_occ[r_lv] <= 1'b1;
            if (r_state == S_OUT && out_go) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tid <= in_tid;
            r_lv <= in_lv;
            r_rot <= (i_in.mode == MODE_ROTATE);
            r_status <= dec_status;
            r_resched <= dec_add && (8'(in_lv) < i_in.running_priority);
        end
        if (r_state == S_RD_HEAD) begin
            r_lv <= lvl_q;
            r_nx <= nxt_q;
            r_pv <= prv_q;
        end
        if (r_state == S_APP_RDP) r_h <= head_q;
        if (r_state == S_FIND) begin
            r_hp <= find_hp;
            r_any <= find_any;
        end
        if (r_state == S_OUT && out_go) begin
            r_out.status <= r_status;
            r_out.need_resched <= r_resched;
            r_out.any_ready <= (r_cnt != '0);
            r_out.highest_priority <= 8'(r_hp);
            r_out.highest_thread <= r_any ? 6'(head_q) : 6'd0;
            r_out.ready_count <= 7'(r_cnt);
        end
    end

    assign o_valid = r_ovalid;
    assign o_out = r_out;
endmodule

// File: design/prq_checker.sv
// port-level checks of the priority ready queue, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module prq_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input prq_pkg::t_out_item o_out
);
    import prq_pkg::*;

    `PRQ_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_out))
    `PRQ_ASSERT_IMP(a_any_cnt, o_valid, o_out.any_ready == (o_out.ready_count != 7'd0))
    `PRQ_ASSERT_IMP(a_empty_hp, o_valid && !o_out.any_ready, o_out.highest_priority == 8'd0)
    `PRQ_ASSERT_IMP(a_resched_done, o_valid && o_out.need_resched, o_out.status == ST_DONE)
    `PRQ_ASSERT_NXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
endmodule

bind priority_ready_queue_top prq_port_checker u_prq_port_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out));

// File: verif/prq_checker.sv
// checker for the priority ready queue: predicts each result and compares it
`timescale 1ns / 1ps
module prq_checker
    import prq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic      i_valid,
    input  logic      o_stall,
    input  t_in_item  i_in,
    input  logic      o_valid,
    input  logic      i_stall,
    input  t_out_item o_out,
    output int        o_fail_count,
    output int        o_pending
);

    logic [5:0]  ring_next [64];
    logic [5:0]  ring_prev [64];
    logic        is_queued [64];
    logic [7:0]  added_level [64];
    logic [5:0]  head_of [256];
    logic [31:0] occ_word [8];
    logic [7:0]  occ_group;
    logic [6:0]  queued_total;
    logic [5:0]  idle_id;
    t_out_item   expected_results [$];

    function automatic logic occupied(input logic [7:0] lv);
        return occ_word[lv[7:5]][lv[4:0]];
    endfunction

    task automatic ring_append(input logic [5:0] t, input logic [7:0] lv);
        logic [5:0] h, tl;
        if (occupied(lv)) begin
            h = head_of[lv];
            tl = ring_prev[h];
            ring_next[tl] = t;
            ring_prev[t] = tl;
            ring_next[t] = h;
            ring_prev[h] = t;
        end else begin
            head_of[lv] = t;
            ring_next[t] = t;
            ring_prev[t] = t;
            occ_group[lv[7:5]] = 1'b1;
            occ_word[lv[7:5]][lv[4:0]] = 1'b1;
        end
    endtask

    task automatic ring_unlink(input logic [5:0] t, input logic [7:0] lv);
        logic [5:0] nx, pv;
        nx = ring_next[t];
        pv = ring_prev[t];
        if (nx == t) begin
            occ_word[lv[7:5]][lv[4:0]] = 1'b0;
            if (occ_word[lv[7:5]] == '0) occ_group[lv[7:5]] = 1'b0;
            head_of[lv] = '0;
        end else begin
            ring_prev[nx] = pv;
            ring_next[pv] = nx;
            if (head_of[lv] == t) head_of[lv] = nx;
        end
    endtask

    task automatic queue_step(input t_in_item it, output t_out_item r);
        logic [5:0] t;
        logic [7:0] lv;
        int g, b;
        t = it.thread_id;
        r = '0;
        r.status = ST_DONE;
        case (it.mode)
            MODE_ADD: begin
                if (it.suspended) r.status = ST_SUSPENDED;
                else if (is_queued[t]) r.status = ST_QUEUED;
                else begin
                    ring_append(t, it.priority_req);
                    added_level[t] = it.priority_req;
                    is_queued[t] = 1'b1;
                    queued_total++;
                    r.need_resched = it.priority_req < it.running_priority;
                end
            end
            MODE_REMOVE: begin
                if (t == idle_id || !is_queued[t]) r.status = ST_IGNORED;
                else begin
                    ring_unlink(t, added_level[t]);
                    is_queued[t] = 1'b0;
                    if (queued_total != 0) queued_total--;
                end
            end
            MODE_ROTATE: begin
                if (!is_queued[t]) r.status = ST_IGNORED;
                else if (ring_next[t] != t) begin
                    lv = added_level[t];
                    if (head_of[lv] == t) head_of[lv] = ring_next[t];
                    else begin
                        ring_unlink(t, lv);
                        ring_append(t, lv);
                    end
                end
            end
            default: r.status = ST_IGNORED;
        endcase
        if (occ_group != '0) begin
            g = 0;
            while (g < 7 && !occ_group[g]) g++;
            b = 0;
            while (b < 31 && !occ_word[g][b]) b++;
            r.highest_priority = 8'(g * 32 + b);
            r.highest_thread = head_of[r.highest_priority];
        end
        r.any_ready = queued_total != 0;
        r.ready_count = queued_total;
    endtask

    always @(posedge i_clk) begin
        t_out_item r, e;
        if (!i_rst_n) begin
            for (int i = 0; i < 64; i++) is_queued[i] = 1'b0;
            for (int i = 0; i < 8; i++) occ_word[i] = '0;
            occ_group = '0;
            queued_total = '0;
            idle_id = '0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) idle_id = i_cfg_wdata;
            if (i_valid && !o_stall) begin
                queue_step(i_in, r);
                expected_results.push_back(r);
            end
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item pending");
                    o_fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_out.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_out.status);
                        o_fail_count++;
                    end
                    if (o_out.need_resched !== e.need_resched) begin
                        $error("need_resched exp %0d got %0d", e.need_resched,
                               o_out.need_resched);
                        o_fail_count++;
                    end
                    if (o_out.any_ready !== e.any_ready) begin
                        $error("any_ready exp %0d got %0d", e.any_ready, o_out.any_ready);
                        o_fail_count++;
                    end
                    if (o_out.highest_priority !== e.highest_priority) begin
                        $error("highest_priority exp %0d got %0d", e.highest_priority,
                               o_out.highest_priority);
                        o_fail_count++;
                    end
                    if (o_out.highest_thread !== e.highest_thread) begin
                        $error("highest_thread exp %0d got %0d", e.highest_thread,
                               o_out.highest_thread);
                        o_fail_count++;
                    end
                    if (o_out.ready_count !== e.ready_count) begin
                        $error("ready_count exp %0d got %0d", e.ready_count,
                               o_out.ready_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: verif/priority_ready_queue_top_tb.sv
// testbench top for the priority ready queue: stimulus, stalls and verdict
`timescale 1ns / 1ps
module priority_ready_queue_top_tb;
    import prq_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [5:0] i_cfg_wdata;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_in;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_out;
    int        fail_count;
    int        pending;
    int        stall_style;
    int        stall_tick;

    priority_ready_queue_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_in(i_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out)
    );

    prq_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_in(i_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // receiver stall pattern in one of four styles, picked anew at random
    always @(negedge i_clk) begin
        stall_tick++;
        if (stall_tick % 300 == 0) stall_style = $urandom_range(0, 3);
        case (stall_style)
            0: i_stall = 1'b0;
            1: i_stall = ($urandom_range(0, 3) == 0);
            2: i_stall = ($urandom_range(0, 3) != 0);
            default: i_stall = ((stall_tick / 7) % 2 == 1);
        endcase
    end

    function automatic t_in_item mk(input logic [1:0] m, input logic [5:0] t,
                                    input logic [7:0] p, input logic [7:0] rp,
                                    input logic s);
        t_in_item it;
        it.mode = m;
        it.thread_id = t;
        it.priority_req = p;
        it.running_priority = rp;
        it.suspended = s;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_in = it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic drain_and_set_idle(input logic [5:0] v);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_in_item random_op();
        int sel;
        logic [1:0] m;
        logic [5:0] t;
        logic [7:0] p;
        sel = $urandom_range(0, 99);
        if (sel < 42) m = MODE_ADD;
        else if (sel < 70) m = MODE_REMOVE;
        else if (sel < 95) m = MODE_ROTATE;
        else m = MODE_NONE;
        t = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 15)) : 6'($urandom);
        case ($urandom_range(0, 3))
            0: p = 8'($urandom_range(0, 3));
            1: p = 8'(32 * $urandom_range(0, 7) + $urandom_range(0, 1));
            2: p = 8'(255 - $urandom_range(0, 2));
            default: p = 8'($urandom);
        endcase
        return mk(m, t, p, 8'($urandom), ($urandom_range(0, 9) == 0));
    endfunction

    initial begin
        int burst;
        int sent;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_valid = 1'b0;
        i_in = '0;
        i_stall = 1'b0;
        stall_style = 0;
        stall_tick = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        drain_and_set_idle(6'd5);
        send_item(mk(MODE_ADD, 6'd5, 8'd0, 8'd255, 1'b0));
        send_item(mk(MODE_ADD, 6'd63, 8'd255, 8'd0, 1'b0));
        send_item(mk(MODE_ADD, 6'd5, 8'd3, 8'd255, 1'b0));
        send_item(mk(MODE_ADD, 6'd7, 8'd4, 8'd255, 1'b1));
        send_item(mk(MODE_REMOVE, 6'd5, 8'd0, 8'd0, 1'b0));
        send_item(mk(MODE_REMOVE, 6'd9, 8'd0, 8'd0, 1'b0));
        send_item(mk(MODE_ROTATE, 6'd9, 8'd0, 8'd0, 1'b0));
        send_item(mk(MODE_ROTATE, 6'd63, 8'd255, 8'd0, 1'b0));
        send_item(mk(MODE_ADD, 6'd10, 8'd255, 8'd255, 1'b0));
        send_item(mk(MODE_ADD, 6'd11, 8'd255, 8'd254, 1'b0));
        send_item(mk(MODE_ROTATE, 6'd63, 8'd0, 8'd0, 1'b0));
        send_item(mk(MODE_ROTATE, 6'd11, 8'd12, 8'd0, 1'b0));
        send_item(mk(MODE_ROTATE, 6'd10, 8'd255, 8'd0, 1'b0));
        send_item(mk(MODE_NONE, 6'd10, 8'd255, 8'd255, 1'b1));
        send_item(mk(MODE_REMOVE, 6'd11, 8'd7, 8'd0, 1'b0));
        send_item(mk(MODE_REMOVE, 6'd63, 8'd255, 8'd0, 1'b0));
        send_item(mk(MODE_ADD, 6'd0, 8'd32, 8'd33, 1'b0));
        send_item(mk(MODE_ADD, 6'd1, 8'd31, 8'd31, 1'b0));
        send_item(mk(MODE_ADD, 6'd42, 8'd170, 8'd85, 1'b0));
        send_item(mk(MODE_REMOVE, 6'd1, 8'd0, 8'd0, 1'b0));
        send_item(mk(MODE_REMOVE, 6'd10, 8'd0, 8'd0, 1'b0));
        send_item(mk(MODE_REMOVE, 6'd5, 8'd0, 8'd0, 1'b0));

        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: drain_and_set_idle(6'd63);
                1: drain_and_set_idle(6'd0);
                2: drain_and_set_idle(6'($urandom));
                default: drain_and_set_idle(6'd42);
            endcase
            while (sent < 500 * (phase + 1)) begin
                burst = $urandom_range(1, 20);
                repeat (burst) begin
                    send_item(random_op());
                    sent++;
                end
                if ($urandom_range(0, 2) != 0) begin
                    @(negedge i_clk);
                    i_valid = 1'b0;
                    repeat ($urandom_range(0, 12)) @(negedge i_clk);
                end
            end
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
